// File: sv/kcg_pkg.sv
// Shared widths, register indexes and controller/datapath structs of the combination generator.
package kcg_pkg;

   localparam int N_TOTAL_W  = 6;
   localparam int K_CHOOSE_W = 5;
   localparam int VALUE_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam int DEF_MAX_N = 32;
   localparam int DEF_MAX_K = 16;

   localparam logic [N_TOTAL_W-1:0]  N_TOTAL_RESET  = 6'd4;
   localparam logic [K_CHOOSE_W-1:0] K_CHOOSE_RESET = 5'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_N_TOTAL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K_CHOOSE = 2'd1;

   typedef struct packed {
      logic start;      // first combination: refill from position 0
      logic scan_load;  // begin scan at the top position
      logic scan_dec;   // move scan one position down
      logic pivot;      // scan hit: latch pivot, rewind to position 0
      logic emit;       // send one element
      logic exh;        // send the exhausted item
   } kcg_cmd_type;

   typedef struct packed {
      logic k_bad;      // k is zero or above n
      logic scan_hit;   // element under scan is below its ceiling
      logic idx_zero;
      logic idx_last;
      logic out_free;   // output register can take an item this cycle
      logic cfg_hit;    // a valid register is being written
   } kcg_status_type;

endpackage

// File: sv/kcg_if.sv
// Channel interfaces: request, response and register write.
interface kcg_req_if import kcg_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface kcg_rsp_if import kcg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] element_value;
   logic               last_of_combination;
   logic               exhausted;

   modport source (output valid, output element_value, output last_of_combination,
                   output exhausted, input ready);
   modport sink   (input valid, input element_value, input last_of_combination,
                   input exhausted, output ready);
endinterface

interface kcg_csr_if import kcg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/kcg_dp.sv
// Datapath: registers, element memory, scan compare, refill and output register.
module kcg_dp import kcg_pkg::*; #(
   parameter int MAX_N = DEF_MAX_N,
   parameter int MAX_K = DEF_MAX_K
) (
   input  logic           clock,
   input  logic           reset,
   kcg_csr_if.sink        csr,
   kcg_rsp_if.source      rsp,
   input  kcg_cmd_type    cmd,
   output kcg_status_type st
);

   localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

   logic [N_TOTAL_W-1:0]  n_total_ff;
   logic [K_CHOOSE_W-1:0] k_choose_ff;
   logic [N_TOTAL_W-1:0]  n_eff;
   logic [K_CHOOSE_W-1:0] k_eff;

   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   pivot_ff;
   logic               fresh_ff;
   logic [VALUE_W-1:0] last_val_ff;
   logic [VALUE_W-1:0] rd_ff;
   logic [VALUE_W-1:0] mem [MAX_K];

   logic [VALUE_W-1:0] value;
   logic               mem_we;
   logic [6:0]         ceiling;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_last_ff;
   logic               rsp_exh_ff;

   // register file
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_total_ff  <= N_TOTAL_RESET;
         k_choose_ff <= K_CHOOSE_RESET;
      end else if (csr.valid && csr.ready) begin
         if (csr.index == CSR_N_TOTAL) begin
            n_total_ff <= csr.data;
         end
         if (csr.index == CSR_K_CHOOSE) begin
            k_choose_ff <= csr.data[K_CHOOSE_W-1:0];
         end
      end
   end

   assign n_eff = (7'(n_total_ff) > 7'(MAX_N)) ? N_TOTAL_W'(MAX_N) : n_total_ff;
   assign k_eff = (7'(k_choose_ff) > 7'(MAX_K)) ? K_CHOOSE_W'(MAX_K) : k_choose_ff;

   assign ceiling = 7'(n_eff) - 7'(k_eff) + 7'(idx_ff) + 7'd1;

   assign st.k_bad    = (k_eff == '0) || (7'(k_eff) > 7'(n_eff));
   assign st.scan_hit = 7'(rd_ff) < ceiling;
   assign st.idx_zero = (idx_ff == '0);
   assign st.idx_last = (7'(idx_ff) == 7'(k_eff) - 7'd1);
   assign st.out_free = !rsp_valid_ff || rsp.ready;
   assign st.cfg_hit  = csr.valid && csr.ready &&
                        ((csr.index == CSR_N_TOTAL) || (csr.index == CSR_K_CHOOSE));

   // below the pivot the stored value stands; at and above it the tail is refilled
   always_comb begin
      if (idx_ff < pivot_ff) begin
         value = rd_ff;
      end else if (idx_ff == pivot_ff && !fresh_ff) begin
         value = rd_ff + VALUE_W'(1);
      end else begin
         value = last_val_ff + VALUE_W'(1);
      end
   end

   assign mem_we = cmd.emit && (idx_ff >= pivot_ff);

   always_comb begin
      idx_in = idx_ff;
      priority if (cmd.start || cmd.pivot) begin
         idx_in = '0;
      end else if (cmd.scan_load) begin
         idx_in = IDX_W'(k_eff - K_CHOOSE_W'(1));
      end else if (cmd.scan_dec) begin
         idx_in = idx_ff - IDX_W'(1);
      end else if (cmd.emit) begin
         idx_in = st.idx_last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pivot_ff    <= '0;
         fresh_ff    <= 1'b1;
         last_val_ff <= '0;
      end else if (cmd.pivot) begin
         pivot_ff <= idx_ff;
         fresh_ff <= 1'b0;
      end else if (cmd.emit) begin
         last_val_ff <= value;
      end
   end

   // element store: one write, one registered read a cycle; read tracks idx
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= value;
      end
      rd_ff <= mem[idx_in];
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit || cmd.exh) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff <= value;
         rsp_last_ff  <= st.idx_last;
         rsp_exh_ff   <= 1'b0;
      end else if (cmd.exh) begin
         rsp_value_ff <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_exh_ff   <= 1'b1;
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.element_value       = rsp_value_ff;
   assign rsp.last_of_combination = rsp_last_ff;
   assign rsp.exhausted           = rsp_exh_ff;

endmodule

// File: sv/kcg_ctrl.sv
// Controller: request handshake, enumeration flags and scan/emit sequencing.
module kcg_ctrl import kcg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   kcg_req_if.sink        req,
   input  kcg_status_type st,
   output kcg_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_EMIT = 4'b0100,
      ST_EXH  = 4'b1000
   } kcg_state_type;

   kcg_state_type state_ff, state_in;
   logic          started_ff, started_in;
   logic          done_ff, done_in;
   logic          req_fire;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      done_in    = done_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.restart || !started_ff) begin
                  started_in = 1'b1;
                  if (st.k_bad) begin
                     done_in  = 1'b1;
                     state_in = ST_EXH;
                  end else begin
                     done_in   = 1'b0;
                     cmd.start = 1'b1;
                     state_in  = ST_EMIT;
                  end
               end else if (done_ff) begin
                  state_in = ST_EXH;
               end else begin
                  cmd.scan_load = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (st.scan_hit) begin
               cmd.pivot = 1'b1;
               state_in  = ST_EMIT;
            end else if (st.idx_zero) begin
               done_in  = 1'b1;
               state_in = ST_EXH;
            end else begin
               cmd.scan_dec = 1'b1;
            end
         end
         ST_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (st.idx_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EXH: begin
            if (st.out_free) begin
               cmd.exh  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // write registers only in idle (unchecked); writes restart enumeration
      if (st.cfg_hit) begin
         started_in = 1'b0;
         done_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
         done_ff    <= done_in;
      end
   end

   a_one_output_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && cmd.exh))
      else $error("emit and exhausted issued together");

   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=>
         (state_ff == ST_SCAN) || (state_ff == ST_EMIT) || (state_ff == ST_EXH))
      else $error("scan left to an unexpected state");

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      st.cfg_hit |=> !started_ff && !done_ff)
      else $error("register write did not restart enumeration");

   a_done_exh: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req.restart && started_ff && done_ff) |=> (state_ff == ST_EXH))
      else $error("request after the end did not give exhausted item");

   a_emit_needs_start: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> started_ff && !done_ff)
      else $error("element sent without a live combination");

endmodule

// File: sv/k_combination_generator_core.sv
// Top level of the k-combination generator: emits the k elements of the next
// combination of 1..n in lexicographic order for each request item, or one
// exhausted item when none remain. A restart item (or the first request after
// reset or a register write) refills the combination from position 0 and emits
// it; a next item first scans the stored combination from the top position
// down, one element a cycle through the element memory, then emits the k
// elements from position 0. A full scan that finds no element below its
// ceiling gives the exhausted result. One item is worked on at a time; a new
// request is taken once the last result is in the output register. The
// element store needs no clearing pass after reset.
module k_combination_generator_core import kcg_pkg::*; #(
   parameter int MAX_N = DEF_MAX_N,
   parameter int MAX_K = DEF_MAX_K
) (
   input logic        clock,
   input logic        reset,
   kcg_req_if.sink    req_ch,
   kcg_rsp_if.source  rsp_ch,
   kcg_csr_if.sink    csr_ch
);

   kcg_cmd_type    cmd;
   kcg_status_type st;

   kcg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .st    (st),
      .cmd   (cmd)
   );

   kcg_dp #(
      .MAX_N (MAX_N),
      .MAX_K (MAX_K)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .rsp   (rsp_ch),
      .cmd   (cmd),
      .st    (st)
   );

endmodule

// File: tb/testbench.sv
// Self-checking bench for the combination generator: random request, response and register traffic.
`timescale 1ns / 100ps

module testbench;
   import kcg_pkg::*;

   localparam int MAX_N      = DEF_MAX_N;
   localparam int MAX_K      = DEF_MAX_K;
   localparam int RANDOM_GOAL = 400;
   localparam int QUIET_TAIL = 40;
   localparam int END_WAIT   = 40;
   localparam int CYCLE_LIMIT = 500000;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               exhausted;
   } element_item_type;

   logic clock;
   logic reset;

   kcg_req_if req_ch ();
   kcg_rsp_if rsp_ch ();
   kcg_csr_if csr_ch ();

   k_combination_generator_core #(
      .MAX_N (MAX_N),
      .MAX_K (MAX_K)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   logic [N_TOTAL_W-1:0]  n_cfg = N_TOTAL_RESET;
   logic [K_CHOOSE_W-1:0] k_cfg = K_CHOOSE_RESET;
   logic [VALUE_W-1:0]    comb_now [MAX_K];
   logic                  seq_started = 1'b0;
   logic                  seq_done = 1'b0;

   element_item_type expected_elements [$];
   logic             pending_restarts [$];

   int          items_queued = 0;
   int          items_taken = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;

   always #10 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void predict_combination(input logic restart);
      int               n_eff;
      int               k_eff;
      int               pos;
      int               j;
      logic             finished;
      element_item_type item;
      n_eff = (n_cfg > MAX_N) ? MAX_N : int'(n_cfg);
      k_eff = (k_cfg > MAX_K) ? MAX_K : int'(k_cfg);
      finished = seq_done;
      if (restart || !seq_started) begin
         seq_started = 1'b1;
         finished = (k_eff == 0 || k_eff > n_eff);
         if (!finished)
            for (j = 0; j < k_eff; j++) comb_now[j] = VALUE_W'(j + 1);
      end else if (!seq_done) begin
         // rightmost element still below its ceiling
         pos = k_eff - 1;
         while (pos >= 0 && int'(comb_now[pos]) >= n_eff - k_eff + pos + 1) pos--;
         if (pos < 0) begin
            finished = 1'b1;
         end else begin
            comb_now[pos] = comb_now[pos] + 1'b1;
            for (j = pos + 1; j < k_eff; j++) comb_now[j] = comb_now[j-1] + 1'b1;
         end
      end
      seq_done = finished;
      if (finished) begin
         item.value = '0;
         item.last = 1'b1;
         item.exhausted = 1'b1;
         expected_elements = {expected_elements, item};
      end else begin
         for (j = 0; j < k_eff; j++) begin
            item.value = comb_now[j];
            item.last = (j == k_eff - 1);
            item.exhausted = 1'b0;
            expected_elements = {expected_elements, item};
         end
      end
   endfunction

   function automatic void queue_item(input logic restart);
      pending_restarts = {pending_restarts, restart};
      items_queued++;
   endfunction

   function automatic void pick_idling();
      int unsigned pick;
      pick = $urandom_range(0, 2);
      gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
      pick = $urandom_range(0, 2);
      stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
   endfunction

   // called at a rising edge; valid is left high for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_N_TOTAL) begin
         n_cfg = val;
         seq_started = 1'b0;
         seq_done = 1'b0;
      end else if (idx == CSR_K_CHOOSE) begin
         k_cfg = val[K_CHOOSE_W-1:0];
         seq_started = 1'b0;
         seq_done = 1'b0;
      end
   endtask

   task automatic set_limits(input logic [CSR_DATA_W-1:0] n_data,
                             input logic [CSR_DATA_W-1:0] k_data);
      if ($urandom_range(0, 1)) begin
         write_reg(CSR_N_TOTAL, n_data);
         write_reg(CSR_K_CHOOSE, k_data);
      end else begin
         write_reg(CSR_K_CHOOSE, k_data);
         write_reg(CSR_N_TOTAL, n_data);
      end
      csr_ch.valid <= 1'b0;
   endtask

   // wait until every item is taken and answered, then let the block go quiet
   task automatic settle();
      do @(posedge clock);
      while (items_taken != items_queued || expected_elements.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_combination(req_ch.restart);
            items_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
               gap_left = $urandom_range(0, 6);
               req_ch.valid <= 1'b0;
            end else if (pending_restarts.size() != 0) begin
               req_ch.valid <= 1'b1;
               req_ch.restart <= pending_restarts.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_mon
      element_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_elements.size() == 0) begin
               report_mismatch($sformatf("unexpected item value %0d last %0b exhausted %0b",
                                         rsp_ch.element_value, rsp_ch.last_of_combination,
                                         rsp_ch.exhausted));
            end else begin
               want = expected_elements.pop_front();
               if (rsp_ch.element_value !== want.value)
                  report_mismatch($sformatf("element_value got %0d want %0d",
                                            rsp_ch.element_value, want.value));
               if (rsp_ch.last_of_combination !== want.last)
                  report_mismatch($sformatf("last_of_combination got %0b want %0b",
                                            rsp_ch.last_of_combination, want.last));
               if (rsp_ch.exhausted !== want.exhausted)
                  report_mismatch($sformatf("exhausted got %0b want %0b",
                                            rsp_ch.exhausted, want.exhausted));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 6);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                    i;
      int                    run_len;
      int                    random_start;
      int unsigned           mode;
      logic [CSR_DATA_W-1:0] n_data;
      logic [CSR_DATA_W-1:0] k_data;

      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.restart = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_N_TOTAL;
      csr_ch.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset values n=4 k=2: next before any start, walk to the end and past it
      pick_idling();
      for (i = 0; i < 8; i++) queue_item(1'b0);
      queue_item(1'b1);

      // n and k above their maxima; k data with its top bit set
      settle();
      set_limits(6'd63, 6'h3F);
      queue_item(1'b1);
      queue_item(1'b0);

      // writes to unused indexes leave the walk where it was
      settle();
      write_reg(CSR_SPARE_A, 6'h2A);
      write_reg(CSR_SPARE_B, 6'h15);
      csr_ch.valid <= 1'b0;
      queue_item(1'b0);

      // k of zero
      settle();
      write_reg(CSR_K_CHOOSE, 6'h20);
      csr_ch.valid <= 1'b0;
      queue_item(1'b1);
      queue_item(1'b0);

      // k above n
      settle();
      set_limits(6'd3, 6'd5);
      queue_item(1'b1);

      // single combination
      settle();
      set_limits(6'd1, 6'd1);
      queue_item(1'b0);
      queue_item(1'b0);

      settle();
      set_limits(6'd32, 6'd1);
      queue_item(1'b1);
      queue_item(1'b0);
      queue_item(1'b0);

      // empty set
      settle();
      write_reg(CSR_N_TOTAL, 6'd0);
      csr_ch.valid <= 1'b0;
      queue_item(1'b0);

      random_start = items_queued;
      while (items_queued < random_start + RANDOM_GOAL) begin
         settle();
         mode = $urandom_range(0, 9);
         case (mode)
            0: begin
               n_data = CSR_DATA_W'($urandom_range(33, 63));
               k_data = CSR_DATA_W'($urandom_range(16, 63));
            end
            1: begin
               n_data = CSR_DATA_W'($urandom_range(0, 8));
               k_data = $urandom_range(0, 1) ? 6'd0 :
                        CSR_DATA_W'(n_data + $urandom_range(1, 20));
            end
            2: begin
               n_data = CSR_DATA_W'($urandom_range(9, 32));
               k_data = CSR_DATA_W'($urandom_range(1, 16));
            end
            default: begin
               n_data = CSR_DATA_W'($urandom_range(1, 7));
               k_data = CSR_DATA_W'($urandom_range(1, n_data));
            end
         endcase
         if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      CSR_DATA_W'($urandom_range(0, 63)));
         set_limits(n_data, k_data);
         if (items_queued >= random_start + RANDOM_GOAL - QUIET_TAIL) begin
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            pick_idling();
         end
         // mostly long walks, with the odd restart thrown in
         run_len = $urandom_range(4, 40);
         for (i = 0; i < run_len; i++)
            queue_item(i == 0 ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 9) == 0));
      end

      settle();
      repeat (END_WAIT) @(posedge clock);
      if (expected_elements.size() != 0)
         report_mismatch($sformatf("%0d expected items never arrived",
                                   expected_elements.size()));
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sim.f
sv/kcg_pkg.sv
sv/kcg_if.sv
sv/kcg_dp.sv
sv/kcg_ctrl.sv
sv/k_combination_generator_core.sv
tb/testbench.sv
